### hw/rtl/macu_pkg.sv
// Package with shared types, operation codes and the leading-bit counter.
`timescale 1ns / 1ps
`default_nettype none

package macu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FUNC_BITS = 6;
    localparam int CNT_BITS  = 6;

    localparam logic [FUNC_BITS-1:0] FN_MADD  = 6'h00;
    localparam logic [FUNC_BITS-1:0] FN_MADDU = 6'h01;
    localparam logic [FUNC_BITS-1:0] FN_MUL   = 6'h02;
    localparam logic [FUNC_BITS-1:0] FN_MSUB  = 6'h04;
    localparam logic [FUNC_BITS-1:0] FN_CLZ   = 6'h20;
    localparam logic [FUNC_BITS-1:0] FN_CLO   = 6'h21;

    typedef logic [2:0] t_kind;

    localparam t_kind K_MADD  = 3'd0;
    localparam t_kind K_MADDU = 3'd1;
    localparam t_kind K_MUL   = 3'd2;
    localparam t_kind K_MSUB  = 3'd3;
    localparam t_kind K_CLZ   = 3'd4;
    localparam t_kind K_CLO   = 3'd5;
    localparam t_kind K_UNK   = 3'd6;

    typedef struct packed {
        t_kind                kind;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
    } t_op;

    // Leading zero count in five halving steps; an all-zero word gives 32.
    function automatic logic [CNT_BITS-1:0] count_lead_zeros(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] x;
        logic [4:0]           n;
        begin
            x = v;
            n = '0;
            if (x[31:16] == 16'h0) begin
                n[4] = 1'b1;
                x = {x[15:0], 16'h0};
            end
            if (x[31:24] == 8'h0) begin
                n[3] = 1'b1;
                x = {x[23:0], 8'h0};
            end
            if (x[31:28] == 4'h0) begin
                n[2] = 1'b1;
                x = {x[27:0], 4'h0};
            end
            if (x[31:30] == 2'h0) begin
                n[1] = 1'b1;
                x = {x[29:0], 2'h0};
            end
            if (x[31] == 1'b0) begin
                n[0] = 1'b1;
            end
            if (v == '0) begin
                return 6'd32;
            end
            return {1'b0, n};
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/macu_front.sv
// Front end: accepts input items, decodes the function code and queues them.
`timescale 1ns / 1ps
`default_nettype none

module macu_front #(
    parameter int QUEUE_AW = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [71:0]     i_s_axis_tdata,
    output logic                 o_q_valid,
    output macu_pkg::t_op        o_q_op,
    input  wire logic            i_q_pop
);
    import macu_pkg::*;

    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;
    logic [FUNC_BITS-1:0] func;
    t_op                 dec_op;

    assign func = i_s_axis_tdata[5:0];

    always_comb begin
        dec_op.a = i_s_axis_tdata[37:6];
        dec_op.b = i_s_axis_tdata[69:38];
        case (func)
            FN_MADD:  dec_op.kind = K_MADD;
            FN_MADDU: dec_op.kind = K_MADDU;
            FN_MUL:   dec_op.kind = K_MUL;
            FN_MSUB:  dec_op.kind = K_MSUB;
            FN_CLZ:   dec_op.kind = K_CLZ;
            FN_CLO:   dec_op.kind = K_CLO;
            default:  dec_op.kind = K_UNK;
        endcase
    end

    assign o_s_axis_tready = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign push = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid = (r_count != '0);
    assign pop = i_q_pop && o_q_valid;
    assign o_q_op = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= dec_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/macu_back.sv
// Back end: multiply and count stage, then accumulate and output register.
`timescale 1ns / 1ps
`default_nettype none

module macu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire macu_pkg::t_op   i_q_op,
    output logic                 o_q_pop,
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    output logic [103:0]         o_m_axis_tdata
);
    import macu_pkg::*;

    logic                   adv;
    logic                   signed_op;
    logic signed [32:0]     ext_a;
    logic signed [32:0]     ext_b;
    logic signed [65:0]     prod;
    logic [WORD_BITS-1:0]   cnt_src;

    logic                   r_m_valid;
    t_kind                  r_m_kind;
    logic [63:0]            r_m_prod;
    logic [CNT_BITS-1:0]    r_m_cnt;

    logic                   r_o_valid;
    logic [WORD_BITS-1:0]   r_value;
    logic                   r_writes;
    logic                   r_unknown;
    logic [63:0]            r_acc;
    logic [63:0]            n_acc;

    assign adv = !r_o_valid || i_m_axis_tready;
    assign o_q_pop = adv && i_q_valid;

    assign signed_op = (i_q_op.kind != K_MADDU);
    assign ext_a = {signed_op & i_q_op.a[31], i_q_op.a};
    assign ext_b = {signed_op & i_q_op.b[31], i_q_op.b};
    assign prod = ext_a * ext_b;
    assign cnt_src = (i_q_op.kind == K_CLO) ? ~i_q_op.a : i_q_op.a;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_kind <= i_q_op.kind;
            r_m_prod <= prod[63:0];
            r_m_cnt  <= count_lead_zeros(cnt_src);
        end
    end

    always_comb begin
        case (r_m_kind)
            K_MADD, K_MADDU: n_acc = r_acc + r_m_prod;
            K_MSUB:          n_acc = r_acc - r_m_prod;
            default:         n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_m_valid) begin
            r_unknown <= (r_m_kind == K_UNK);
            case (r_m_kind)
                K_MUL: begin
                    r_value  <= r_m_prod[31:0];
                    r_writes <= 1'b1;
                end
                K_CLZ, K_CLO: begin
                    r_value  <= {{(WORD_BITS - CNT_BITS){1'b0}}, r_m_cnt};
                    r_writes <= 1'b1;
                end
                default: begin
                    r_value  <= '0;
                    r_writes <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
        end else if (adv) begin
            r_m_valid <= i_q_valid;
            r_o_valid <= r_m_valid;
            if (r_m_valid) begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'b0, r_unknown, r_acc[31:0], r_acc[63:32], r_writes, r_value};

endmodule

`default_nettype wire

### hw/rtl/multiply_accumulate_count_unit_core.sv
// Items pass the queue, the multiply and count register and the output register.
// One item per cycle unless the output stalls, set by the 64-bit accumulate loop.
// A four-entry queue separates the decoder from the multiply and accumulate stages.
// Reset clears the queue, the stage valid flags and the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module multiply_accumulate_count_unit_core #(
    parameter int QUEUE_AW = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // func[5:0], operand_a[37:6], operand_b[69:38], zero fill above.
    input  wire logic [71:0]  i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // result_value[31:0], writes_register[32], acc_high[64:33], acc_low[96:65],
    // unknown_op[97], zero fill above.
    output logic [103:0]      o_m_axis_tdata
);
    import macu_pkg::*;

    logic q_valid;
    logic q_pop;
    t_op  q_op;

    macu_front #(
        .QUEUE_AW(QUEUE_AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_q_valid       (q_valid),
        .o_q_op          (q_op),
        .i_q_pop         (q_pop)
    );

    macu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (q_op),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### tb/tb_multiply_accumulate_count_unit_core.sv
// Self-checking testbench for the multiply-accumulate and leading-bit count unit.
`timescale 1ns / 1ps

module tb_multiply_accumulate_count_unit_core;
    import macu_pkg::*;

    localparam logic [FUNC_BITS-1:0] FN_MSUBU    = 6'h05;
    localparam logic [FUNC_BITS-1:0] FN_HOLE     = 6'h03;
    localparam logic [FUNC_BITS-1:0] FN_TOP_CODE = 6'h3F;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [FUNC_BITS-1:0] func;
        logic [31:0]          a;
        logic [31:0]          b;
        int                   gap;
    } t_instr;

    typedef struct {
        logic [31:0] value;
        logic        writes;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        unknown;
    } t_retire;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // func, operand_a, operand_b, zero fill.
    logic [71:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // result_value, writes_register, acc_high, acc_low, unknown_op, zero fill.
    logic [103:0] o_m_axis_tdata;

    t_instr      instr_q[$];
    t_retire     retire_q[$];
    t_retire     want;
    logic [63:0] hilo_acc;
    int          errors;
    int          n_checked;
    int          n_accum;
    int          n_mul;
    int          n_count;
    int          n_unknown;
    int          ready_stall;
    int          idle_cycles;
    int          cycle_cnt;
    bit          calm_sender;

    multiply_accumulate_count_unit_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] leading_run(logic [31:0] v, logic bit_val);
        logic [31:0] n;
        logic        going;
        n = '0;
        going = 1'b1;
        for (int i = 31; i >= 0; i--) begin
            if (going && v[i] == bit_val) begin
                n++;
            end else begin
                going = 1'b0;
            end
        end
        return n;
    endfunction

    function automatic t_retire execute_instr(t_instr ins);
        t_retire     r;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] ua;
        logic [63:0] ub;
        sa = {{32{ins.a[31]}}, ins.a};
        sb = {{32{ins.b[31]}}, ins.b};
        ua = {32'h0, ins.a};
        ub = {32'h0, ins.b};
        r.value = '0;
        r.writes = 1'b0;
        r.unknown = 1'b0;
        case (ins.func)
            FN_MUL: begin
                r.value = ins.a * ins.b;
                r.writes = 1'b1;
                n_mul++;
            end
            FN_MADD: begin
                hilo_acc = hilo_acc + sa * sb;
                n_accum++;
            end
            FN_MADDU: begin
                hilo_acc = hilo_acc + ua * ub;
                n_accum++;
            end
            FN_MSUB: begin
                hilo_acc = hilo_acc - sa * sb;
                n_accum++;
            end
            FN_CLZ: begin
                r.value = leading_run(ins.a, 1'b0);
                r.writes = 1'b1;
                n_count++;
            end
            FN_CLO: begin
                r.value = leading_run(ins.a, 1'b1);
                r.writes = 1'b1;
                n_count++;
            end
            default: begin
                r.unknown = 1'b1;
                n_unknown++;
            end
        endcase
        r.hi = hilo_acc[63:32];
        r.lo = hilo_acc[31:0];
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int sel;
        sel = $urandom_range(0, 99);
        if (calm || sel < 70) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4, 5: return $urandom >> $urandom_range(0, 31);
            6, 7: return ~($urandom >> $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FUNC_BITS-1:0] pick_func();
        case ($urandom_range(0, 19))
            0, 1, 2: return FN_MADD;
            3, 4: return FN_MADDU;
            5, 6, 7: return FN_MUL;
            8, 9, 10: return FN_MSUB;
            11, 12, 13: return FN_CLZ;
            14, 15, 16: return FN_CLO;
            17: return FN_MSUBU;
            default: return FUNC_BITS'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic add_instr(logic [FUNC_BITS-1:0] func, logic [31:0] a, logic [31:0] b,
                             int gap);
        t_instr ins;
        ins.func = func;
        ins.a = a;
        ins.b = b;
        ins.gap = gap;
        instr_q.push_back(ins);
    endtask

    task automatic wait_quiet();
        while (instr_q.size() != 0 || i_s_axis_tvalid || retire_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sender: holds an item until it is taken, and counts down gaps in front of the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                retire_q.push_back(execute_instr(instr_q[0]));
                instr_q.pop_front();
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                i_s_axis_tvalid <= 1'b1;
            end else if (instr_q.size() != 0 && instr_q[0].gap == 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {2'b00, instr_q[0].b, instr_q[0].a, instr_q[0].func};
            end else begin
                i_s_axis_tvalid <= 1'b0;
                if (instr_q.size() != 0) instr_q[0].gap--;
            end
        end
    end

    // Receiver: stalls at random except in alternating calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            ready_stall <= 0;
            cycle_cnt <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (ready_stall > 0) begin
                i_m_axis_tready <= 1'b0;
                ready_stall <= ready_stall - 1;
            end else if (cycle_cnt[8] == 1'b0 && $urandom_range(0, 9) < 3) begin
                i_m_axis_tready <= 1'b0;
                ready_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                           : $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (retire_q.size() == 0) begin
                $error("result arrived with no expectation pending");
                errors++;
            end else begin
                want = retire_q.pop_front();
                n_checked++;
                if (o_m_axis_tdata[31:0] !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value,
                           o_m_axis_tdata[31:0]);
                    errors++;
                end
                if (o_m_axis_tdata[32] !== want.writes) begin
                    $error("writes_register: expected %b, got %b", want.writes,
                           o_m_axis_tdata[32]);
                    errors++;
                end
                if (o_m_axis_tdata[64:33] !== want.hi) begin
                    $error("acc_high: expected %h, got %h", want.hi, o_m_axis_tdata[64:33]);
                    errors++;
                end
                if (o_m_axis_tdata[96:65] !== want.lo) begin
                    $error("acc_low: expected %h, got %h", want.lo, o_m_axis_tdata[96:65]);
                    errors++;
                end
                if (o_m_axis_tdata[97] !== want.unknown) begin
                    $error("unknown_op: expected %b, got %b", want.unknown,
                           o_m_axis_tdata[97]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timed out with %0d results still expected.", retire_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        n_checked = 0;
        n_accum = 0;
        n_mul = 0;
        n_count = 0;
        n_unknown = 0;
        idle_cycles = 0;
        hilo_acc = '0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_instr(FN_MUL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_instr(FN_MUL,   32'h8000_0000, 32'h8000_0000, 0);
        add_instr(FN_MUL,   32'h0,         32'hFFFF_FFFF, 1);
        add_instr(FN_MADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_instr(FN_MADD,  32'h8000_0000, 32'h7FFF_FFFF, 0);
        add_instr(FN_MADD,  32'h8000_0000, 32'h8000_0000, 2);
        add_instr(FN_MADDU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_instr(FN_MADDU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_instr(FN_MADDU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_instr(FN_MSUB,  32'h8000_0000, 32'h8000_0000, 0);
        add_instr(FN_MSUB,  32'h7FFF_FFFF, 32'h8000_0000, 3);
        add_instr(FN_MSUB,  32'h0,         32'h0,         0);
        add_instr(FN_CLZ,   32'h0,         32'hFFFF_FFFF, 0);
        add_instr(FN_CLZ,   32'hFFFF_FFFF, 32'h0,         0);
        add_instr(FN_CLZ,   32'h0000_0001, 32'h1234_5678, 0);
        add_instr(FN_CLO,   32'hFFFF_FFFF, 32'h0,         0);
        add_instr(FN_CLO,   32'h0,         32'hFFFF_FFFF, 0);
        add_instr(FN_CLO,   32'hFFFF_FFFE, 32'h0,         0);
        add_instr(FN_MSUBU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_instr(FN_HOLE,  32'h1234_5678, 32'h9ABC_DEF0, 0);
        add_instr(FN_TOP_CODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        wait_quiet();

        for (int batch = 0; batch < 6; batch++) begin
            calm_sender = (batch == 1 || batch == 4);
            for (int k = 0; k < 300; k++) begin
                add_instr(pick_func(), pick_word(), pick_word(), pick_gap(calm_sender));
            end
            if (batch == 2) wait_quiet();
        end
        wait_quiet();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results: %0d accumulate, %0d MUL, %0d count, %0d unknown code.",
                 n_checked, n_accum, n_mul, n_count, n_unknown);
        $display("Final accumulator %h, errors %0d.", hilo_acc, errors);
        if (errors == 0 && retire_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/macu_pkg.sv
hw/rtl/macu_front.sv
hw/rtl/macu_back.sv
hw/rtl/multiply_accumulate_count_unit_core.sv
tb/tb_multiply_accumulate_count_unit_core.sv
